>>> rtl/core/ctt_pkg.sv
// Shared types, constants and the arctangent table for the Cartesian to
// torus coordinate pipeline. No dependencies.
package ctt_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned RADIUS_W    = 32;
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  // CORDIC datapath width: vectors up to ~3.7e9 grow by the CORDIC gain
  localparam int unsigned CORDIC_W    = 36;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RING_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_RADIUS = 2'd1;

  localparam logic [CFG_W-1:0] RING_RADIUS_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] CROSS_RADIUS_RST = 31'd6554;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } ctt_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  theta_angle;
    logic [ANGLE_W-1:0]  phi_angle;
    logic [RADIUS_W-1:0] norm_radius;
    logic                radius_saturated;
  } ctt_out_t;

  // atan(2^-i) as a fraction of a full turn (2^32 = one turn), truncated
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051D;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2E;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2F9;
      5'd15: val = 32'h0000_517C;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A2F;
      5'd19: val = 32'h0000_0517;
      5'd20: val = 32'h0000_028B;
      5'd21: val = 32'h0000_0145;
      5'd22: val = 32'h0000_00A2;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0028;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0002;
      5'd29: val = 32'h0000_0001;
      5'd30: val = 32'h0000_0000;
      5'd31: val = 32'h0000_0000;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/ctt_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor of sqrt).
// Depends on ctt_pkg; stage enables come from the owner's pipeline control.
module ctt_sqrt import ctt_pkg::*; (
  input  logic                   clk_i,
  input  logic [SQRT_STAGES-1:0] en_i,
  input  logic [63:0]            rad_i,
  output logic [31:0]            root_o
);

  logic [63:0] rem_q  [SQRT_STAGES];
  logic [31:0] root_q [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - j;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^B)^2 - root^2, root holds only bits above B
    assign trial = ({32'd0, root_in} << (B + 1)) + (64'd1 << (2 * B));

    // Keep the bit when the remainder covers the trial square
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (32'd1 << B);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

>>> rtl/core/ctt_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) as a 32-bit fraction of a turn.
// Depends on ctt_pkg for the datapath width and the arctangent table.
module ctt_cordic import ctt_pkg::*; #(
  parameter int NITER = 18
) (
  input  logic                       clk_i,
  input  logic [NITER:0]             en_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  output logic [31:0]                angle_o
);

  logic signed [CORDIC_W-1:0] x_q    [NITER+1];
  logic signed [CORDIC_W-1:0] y_q    [NITER+1];
  logic [31:0]                a_q    [NITER+1];
  logic                       zero_q [NITER+1];

  // Pre-rotate: flag the origin, turn the left half plane by half a turn
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        a_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= NITER; s++) begin : g_iter
    localparam int I = s - 1;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    assign xs = x_q[s-1] >>> I;
    assign ys = y_q[s-1] >>> I;

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        zero_q[s] <= zero_q[s-1];
        if (y_q[s-1] < 0) begin
          x_q[s] <= x_q[s-1] - ys;
          y_q[s] <= y_q[s-1] + xs;
          a_q[s] <= a_q[s-1] - atan_turn(5'(I));
        end else begin
          x_q[s] <= x_q[s-1] + ys;
          y_q[s] <= y_q[s-1] - xs;
          a_q[s] <= a_q[s-1] + atan_turn(5'(I));
        end
      end
    end
  end

  assign angle_o = zero_q[NITER] ? 32'd0 : a_q[NITER];

endmodule

>>> rtl/core/cartesian_to_torus_coords.sv
// Cartesian point to torus coordinates: top level with pipeline control,
// squares, divider and delay lines. Depends on ctt_pkg, ctt_sqrt, ctt_cordic.
//
// Usage: one point (x, y, z, signed Q16.16) per transfer on the input
// channel (in_valid_i/in_ready_o/in_data_i); one result per point on the
// output channel (out_valid_o/out_ready_i/out_data_o) in input order.
// Result fields: theta and phi as fractions of a full turn, the distance
// from the ring circle over the tube radius (unsigned Q16.16, saturating)
// and a saturation flag.
// Pipeline depth: 104 stages. Throughput: one point per cycle while
// nothing stalls, set by the fully pipelined datapath (two 32-stage
// square roots, a 32-stage restoring divider, two CORDIC units of
// CORDIC_ITERATIONS+1 stages running beside them).
// Stall: each stage holds while its successor is full and stalled; empty
// stages keep filling, so in_ready_o drops only when all stages are full.
// Reset clears all stage valid bits and loads the register defaults. The
// configuration port (cfg_valid_i, cfg_index_i, cfg_data_i) is always
// ready; the user must write only while the pipeline is empty, the block does not enforce it.
module cartesian_to_torus_coords import ctt_pkg::*; #(
  parameter int ANGLE_BITS        = 16,
  parameter int CORDIC_ITERATIONS = 18
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ctt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctt_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NC        = CORDIC_ITERATIONS + 1;
  localparam int ST_SQ1    = 1;
  localparam int ST_SUM1   = 2;
  localparam int SQ1_BASE  = 3;
  localparam int ST_D      = SQ1_BASE + SQRT_STAGES;
  localparam int ST_SQ2    = ST_D + 1;
  localparam int ST_SUM2   = ST_D + 2;
  localparam int SQ2_BASE  = ST_D + 3;
  localparam int ST_CMP    = SQ2_BASE + SQRT_STAGES;
  localparam int DIV_BASE  = ST_CMP + 1;
  localparam int ST_OUT    = DIV_BASE + DIV_STAGES;
  localparam int NSTG      = ST_OUT + 1;
  localparam int TH_END    = NC;
  localparam int PH_BASE   = ST_D + 1;
  localparam int PH_END    = PH_BASE + NC - 1;
  localparam int ANG_SHIFT = 32 - ANGLE_BITS;

  // Configuration registers
  logic [CFG_W-1:0] ring_radius_q;
  logic [CFG_W-1:0] cross_radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_radius_q  <= RING_RADIUS_RST;
      cross_radius_q <= CROSS_RADIUS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RING_RADIUS:  ring_radius_q  <= cfg_data_i[CFG_W-1:0];
        REG_CROSS_RADIUS: cross_radius_q <= cfg_data_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance enables
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] v_in;
  logic [NSTG:0]   en;

  assign en[NSTG] = out_ready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign v_in = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];

  // Input stage and z delay line
  logic signed [COORD_W-1:0] x0_q;
  logic signed [COORD_W-1:0] y0_q;
  logic signed [COORD_W-1:0] z_q [0:ST_D];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q   <= in_data_i.x_coord;
      y0_q   <= in_data_i.y_coord;
      z_q[0] <= in_data_i.z_coord;
    end
  end

  for (genvar k = 1; k <= ST_D; k++) begin : g_zline
    always_ff @(posedge clk_i) begin
      if (en[k]) z_q[k] <= z_q[k-1];
    end
  end

  // Squares of |x| and |y|, then their sum
  logic [31:0] ux;
  logic [31:0] uy;
  logic [63:0] sqx_q;
  logic [63:0] sqy_q;
  logic [63:0] s1_q;

  assign ux = x0_q[31] ? 32'(-x0_q) : 32'(x0_q);
  assign uy = y0_q[31] ? 32'(-y0_q) : 32'(y0_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ1]) begin
      sqx_q <= ux * ux;
      sqy_q <= uy * uy;
    end
    if (en[ST_SUM1]) s1_q <= sqx_q + sqy_q;
  end

  // Distance from the z axis
  logic [31:0] rplane;

  ctt_sqrt u_sqrt_plane (
    .clk_i  (clk_i),
    .en_i   (en[SQ1_BASE +: SQRT_STAGES]),
    .rad_i  (s1_q),
    .root_o (rplane)
  );

  // Offset from the ring circle in the point's meridian plane
  logic signed [33:0] d_q;
  logic [31:0]        ud;
  logic [31:0]        uz;
  logic [63:0]        sqd_q;
  logic [63:0]        sqz_q;
  logic [63:0]        s2_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_D]) d_q <= $signed({2'b00, rplane}) - $signed({3'b000, ring_radius_q});
  end

  assign ud = d_q[33] ? 32'(-d_q) : 32'(d_q);
  assign uz = z_q[ST_D][31] ? 32'(-z_q[ST_D]) : 32'(z_q[ST_D]);

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ2]) begin
      sqd_q <= ud * ud;
      sqz_q <= uz * uz;
    end
    if (en[ST_SUM2]) s2_q <= sqd_q + sqz_q;
  end

  logic [31:0] dist_root;

  ctt_sqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en[SQ2_BASE +: SQRT_STAGES]),
    .rad_i  (s2_q),
    .root_o (dist_root)
  );

  // Ring angle from (x, y), phi from (d, z)
  logic [31:0] theta_ang;
  logic [31:0] phi_ang;

  ctt_cordic #(.NITER(CORDIC_ITERATIONS)) u_cordic_theta (
    .clk_i   (clk_i),
    .en_i    (en[1 +: NC]),
    .x_i     (CORDIC_W'(x0_q)),
    .y_i     (CORDIC_W'(y0_q)),
    .angle_o (theta_ang)
  );

  ctt_cordic #(.NITER(CORDIC_ITERATIONS)) u_cordic_phi (
    .clk_i   (clk_i),
    .en_i    (en[PH_BASE +: NC]),
    .x_i     (CORDIC_W'(d_q)),
    .y_i     (CORDIC_W'(z_q[ST_D])),
    .angle_o (phi_ang)
  );

  // Hold the angles until the divider finishes
  logic [31:0] th_q [TH_END+1:ST_OUT-1];
  logic [31:0] ph_q [PH_END+1:ST_OUT-1];

  for (genvar k = TH_END + 1; k <= ST_OUT - 1; k++) begin : g_thline
    if (k == TH_END + 1) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[k]) th_q[k] <= theta_ang;
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en[k]) th_q[k] <= th_q[k-1];
      end
    end
  end

  for (genvar k = PH_END + 1; k <= ST_OUT - 1; k++) begin : g_phline
    if (k == PH_END + 1) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[k]) ph_q[k] <= phi_ang;
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en[k]) ph_q[k] <= ph_q[k-1];
      end
    end
  end

  // Divider: overflow check, then one quotient bit per stage
  logic [31:0] rem_q [ST_CMP:ST_OUT-1];
  logic [31:0] low_q [ST_CMP:ST_OUT-1];
  logic [31:0] quo_q [ST_CMP:ST_OUT-1];
  logic        sat_q [ST_CMP:ST_OUT-1];

  // Quotient overflows 32 bits exactly when the distance >= divisor * 2^16
  always_ff @(posedge clk_i) begin
    if (en[ST_CMP]) begin
      sat_q[ST_CMP] <= {15'd0, dist_root} >= {cross_radius_q, 16'd0};
      rem_q[ST_CMP] <= {16'd0, dist_root[31:16]};
      low_q[ST_CMP] <= {dist_root[15:0], 16'd0};
      quo_q[ST_CMP] <= '0;
    end
  end

  for (genvar k = DIV_BASE; k <= ST_OUT - 1; k++) begin : g_div
    logic [31:0] part;
    logic        ge;

    assign part = {rem_q[k-1][30:0], low_q[k-1][31]};
    assign ge   = part >= {1'b0, cross_radius_q};

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= ge ? part - {1'b0, cross_radius_q} : part;
        low_q[k] <= {low_q[k-1][30:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][30:0], ge};
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  // Output register
  logic [31:0] th_sh;
  logic [31:0] ph_sh;
  ctt_out_t    out_q;

  assign th_sh = th_q[ST_OUT-1] >> ANG_SHIFT;
  assign ph_sh = ph_q[ST_OUT-1] >> ANG_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q.theta_angle      <= th_sh[ANGLE_W-1:0];
      out_q.phi_angle        <= ph_sh[ANGLE_W-1:0];
      out_q.norm_radius      <= sat_q[ST_OUT-1] ? '1 : quo_q[ST_OUT-1];
      out_q.radius_saturated <= sat_q[ST_OUT-1];
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/ctt_checker.sv
// Port-level checks for cartesian_to_torus_coords, bound to the top level.
// Depends on ctt_pkg for the payload types.
module ctt_port_checks import ctt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input ctt_out_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // Input backpressure only when the output side is full and stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // Saturation flag and clamped value agree
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.radius_saturated |-> out_data_o.norm_radius == '1)
    else $error("saturated result not clamped");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind cartesian_to_torus_coords ctt_port_checks u_ctt_port_checks (.*);
